// ===== design/wcd_pkg.sv =====
// Shared types and constants for the worker credit dispatcher.
// Used by wcd_cell and worker_credit_dispatcher_core; no dependencies.
package wcd_pkg;

   localparam int NUM_SLOTS         = 16;
   localparam int SLOT_BITS         = $clog2(NUM_SLOTS);
   localparam int NUM_QUEUES        = 16;
   localparam int QUEUE_BITS        = $clog2(NUM_QUEUES);
   localparam int COUNT_BITS        = 8;
   localparam int WORKER_COUNT_BITS = $clog2(NUM_SLOTS + 1);
   localparam int CMD_BITS          = 3;
   localparam int TAG_BITS          = 32;
   localparam int PRIO_BITS         = 8;
   localparam int PREF_BITS         = 16;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_REGISTER = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_ASSIGN   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_DRAIN    = 3'd4;

   // One request as it travels down the cell chain, with its partial result
   typedef struct packed {
      logic                         valid;
      logic [CMD_BITS-1:0]          command;
      logic [SLOT_BITS-1:0]         worker_slot;
      logic [NUM_QUEUES-1:0]        queue_mask;
      logic [COUNT_BITS-1:0]        concurrency_limit;
      logic [QUEUE_BITS-1:0]        queue_id;
      logic [TAG_BITS-1:0]          job_tag;
      logic [PRIO_BITS-1:0]         job_priority;
      logic [PREF_BITS-1:0]         payload_ref;
      logic                         granted;
      logic [SLOT_BITS-1:0]         chosen_slot;
      logic [WORKER_COUNT_BITS-1:0] worker_count;
      logic [COUNT_BITS-1:0]        slot_job_count;
   } wcd_pkt_type;

endpackage

// ===== design/worker_credit_dispatcher_core.sv =====
// A request's result passes one register per slot cell of the chain before it
// reaches the ports; rsp_strobe marks it for one cycle.
// Throughput: one request per cycle, sustained while busy is low; results keep request order.
// Reset (synchronous, active high): clears all slots; busy is high during reset
// and for the cycle after it. The result side has no stall.
module worker_credit_dispatcher_core
   import wcd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [CMD_BITS-1:0]          req_command,
   input  logic [SLOT_BITS-1:0]         req_worker_slot,
   input  logic [NUM_QUEUES-1:0]        req_queue_mask,
   input  logic [COUNT_BITS-1:0]        req_concurrency_limit,
   input  logic [QUEUE_BITS-1:0]        req_queue_id,
   input  logic [TAG_BITS-1:0]          req_job_tag,
   input  logic [PRIO_BITS-1:0]         req_job_priority,
   input  logic [PREF_BITS-1:0]         req_payload_ref,
   output logic                         rsp_strobe,
   output logic                         rsp_granted,
   output logic [SLOT_BITS-1:0]         rsp_chosen_slot,
   output logic [TAG_BITS-1:0]          rsp_job_tag_out,
   output logic [PRIO_BITS-1:0]         rsp_priority_out,
   output logic [PREF_BITS-1:0]         rsp_payload_ref_out,
   output logic [WORKER_COUNT_BITS-1:0] rsp_worker_count,
   output logic [COUNT_BITS-1:0]        rsp_slot_job_count
);

   logic        busy_ff;
   wcd_pkt_type link [NUM_SLOTS+1];
   wcd_pkt_type last_pkt;

   // Hold busy through reset and the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // Build the request entering the first cell
   always_comb begin
      link[0].valid             = start && !busy_ff;
      link[0].command           = req_command;
      link[0].worker_slot       = req_worker_slot;
      link[0].queue_mask        = req_queue_mask;
      link[0].concurrency_limit = req_concurrency_limit;
      link[0].queue_id          = req_queue_id;
      link[0].job_tag           = req_job_tag;
      link[0].job_priority      = req_job_priority;
      link[0].payload_ref       = req_payload_ref;
      link[0].granted           = 1'b0;
      link[0].chosen_slot       = '0;
      link[0].worker_count      = '0;
      link[0].slot_job_count    = '0;
   end

   // Chain of slot cells, lowest slot first
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      wcd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_id  (SLOT_BITS'(i)),
         .up_pkt   (link[i]),
         .down_pkt (link[i+1])
      );
   end

   assign last_pkt = link[NUM_SLOTS];

   // Drive results; drop job fields when nothing was granted
   assign rsp_strobe          = last_pkt.valid;
   assign rsp_granted         = last_pkt.granted;
   assign rsp_chosen_slot     = last_pkt.chosen_slot;
   assign rsp_job_tag_out     = last_pkt.granted ? last_pkt.job_tag : '0;
   assign rsp_priority_out    = last_pkt.granted ? last_pkt.job_priority : '0;
   assign rsp_payload_ref_out = last_pkt.granted ? last_pkt.payload_ref : '0;
   assign rsp_worker_count    = last_pkt.worker_count;
   assign rsp_slot_job_count  = last_pkt.slot_job_count;

`ifndef SYNTHESIS
   // A grant always leaves its slot with at least one job
   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_granted |-> rsp_slot_job_count != '0)
      else $error("grant reported with zero job count");

   // Non-assign requests never report a grant
   a_grant_only_assign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (last_pkt.command != CMD_ASSIGN) |-> !rsp_granted)
      else $error("grant on a non-assign request");

   // Ungranted results name slot zero
   a_ungranted_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_granted |-> rsp_chosen_slot == '0)
      else $error("ungranted result names a slot");
`endif

endmodule

// ===== design/wcd_cell.sv =====
// One worker slot of the dispatcher chain: holds the slot state and applies
// each passing request, then hands it to the next cell. Depends on wcd_pkg.
module wcd_cell
   import wcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SLOT_BITS-1:0] slot_id,
   input  wcd_pkt_type          up_pkt,
   output wcd_pkt_type          down_pkt
);

   logic                  valid_ff, valid_in;
   logic                  drain_ff, drain_in;
   logic [COUNT_BITS-1:0] jobs_ff, jobs_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   logic [NUM_QUEUES-1:0] mask_ff, mask_in;
   wcd_pkt_type           fwd_ff, fwd_in;

   logic addressed;
   logic eligible;
   logic slot_cmd;

   // Decode what the passing request means for this slot
   always_comb begin
      addressed = (up_pkt.worker_slot == slot_id);
      eligible  = valid_ff && !drain_ff && (jobs_ff < limit_ff) &&
                  mask_ff[up_pkt.queue_id] && !up_pkt.granted;
      slot_cmd  = (up_pkt.command == CMD_REGISTER) || (up_pkt.command == CMD_REMOVE) ||
                  (up_pkt.command == CMD_RELEASE)  || (up_pkt.command == CMD_DRAIN);
   end

   // Update slot state and the request's partial result
   always_comb begin
      valid_in = valid_ff;
      drain_in = drain_ff;
      jobs_in  = jobs_ff;
      limit_in = limit_ff;
      mask_in  = mask_ff;
      fwd_in   = up_pkt;
      if (up_pkt.valid) begin
         case (up_pkt.command)
            CMD_REGISTER: begin
               if (addressed) begin
                  if (!valid_ff) begin
                     valid_in = 1'b1;
                     drain_in = 1'b0;
                     jobs_in  = '0;
                  end
                  mask_in  = up_pkt.queue_mask;
                  limit_in = up_pkt.concurrency_limit;
               end
            end
            CMD_REMOVE: begin
               if (addressed) begin
                  valid_in = 1'b0;
                  drain_in = 1'b0;
                  jobs_in  = '0;
                  limit_in = '0;
                  mask_in  = '0;
               end
            end
            CMD_RELEASE: begin
               if (addressed && valid_ff && (jobs_ff != '0)) begin
                  jobs_in = jobs_ff - 1'b1;
               end
            end
            CMD_ASSIGN: begin
               // first fit: only the lowest eligible cell sees granted low
               if (eligible) begin
                  jobs_in               = jobs_ff + 1'b1;
                  fwd_in.granted        = 1'b1;
                  fwd_in.chosen_slot    = slot_id;
                  fwd_in.slot_job_count = jobs_ff + 1'b1;
               end
            end
            CMD_DRAIN: begin
               if (addressed && valid_ff) begin
                  drain_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (addressed && slot_cmd) begin
            fwd_in.slot_job_count = jobs_in;
         end
         fwd_in.worker_count = up_pkt.worker_count + WORKER_COUNT_BITS'(valid_in);
      end
   end

   // Hold slot state; advance the request to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         drain_ff <= 1'b0;
         jobs_ff  <= '0;
         limit_ff <= '0;
         mask_ff  <= '0;
         fwd_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         drain_ff <= drain_in;
         jobs_ff  <= jobs_in;
         limit_ff <= limit_in;
         mask_ff  <= mask_in;
         fwd_ff   <= fwd_in;
      end
   end

   assign down_pkt = fwd_ff;

`ifndef SYNTHESIS
   // An empty slot carries no jobs and no drain mark
   a_empty_slot_clean: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> (jobs_ff == '0) && !drain_ff)
      else $error("empty slot holds jobs or drain mark");

   // A grant made here leaves the reported count in the slot
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      fwd_ff.valid && fwd_ff.granted && (fwd_ff.chosen_slot == slot_id)
         |-> (jobs_ff == fwd_ff.slot_job_count) && (jobs_ff != '0))
      else $error("granted count does not match slot count");

   // Grants only come from this cell or cells upstream
   a_grant_upstream: assert property (@(posedge clock) disable iff (reset)
      fwd_ff.valid && fwd_ff.granted |-> fwd_ff.chosen_slot <= slot_id)
      else $error("grant from a downstream slot");

   // Running worker count cannot exceed the cells passed so far
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fwd_ff.valid |->
         fwd_ff.worker_count <= ({1'b0, slot_id} + WORKER_COUNT_BITS'(1)))
      else $error("worker count exceeds cells passed");
`endif

endmodule
